FILE: rtl/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

   // Table geometry and field widths.
   localparam int MAX_TASKS = 8;
   localparam int SLOT_W    = 3;
   localparam int COUNT_W   = 4;
   localparam int TICK_W    = 32;
   localparam int TOTAL_W   = 32;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int OUTCOME_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_SET_EN   = 2'd1,
      FUNC_DISPATCH = 2'd2,
      FUNC_REPORT   = 2'd3
   } func_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_OK       = 2'd0,
      OUT_FULL     = 2'd1,
      OUT_NONE_DUE = 2'd2,
      OUT_IGNORED  = 2'd3
   } outcome_type;

   // Returned task status codes; any other value counts as "other".
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd1;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/periodic_task_dispatcher.sv
`default_nettype none

// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+------------------------------
// request   | req_func to req_task_status, six fields       | taken when start high, busy low
// response  | rsp_outcome, rsp_issued_slot, rsp_*_total     | one-cycle strobe rsp_valid
//
// Add, set-enable, report, an ignored dispatch and a re-issuing dispatch answer in the cycle after they
// are taken with busy kept low, so such items can follow one another in every cycle.
// A scanning dispatch holds busy high while one shared subtract and compare unit
// examines a slot per cycle, from slot 0 on, until it finds a due slot or passes
// the last used slot; the result is shown in the following cycle.
// Synchronous reset clears the control state, not the tables; the receiver cannot stall.

module periodic_task_dispatcher (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ptd_pkg::FUNC_W-1:0]        req_func,
   input  wire logic [ptd_pkg::TICK_W-1:0]        req_period_ticks,
   input  wire logic                              req_enable_bit,
   input  wire logic [ptd_pkg::SLOT_W-1:0]        req_slot_index,
   input  wire logic [ptd_pkg::TICK_W-1:0]        req_now_tick,
   input  wire logic [ptd_pkg::STATUS_W-1:0]      req_task_status,
   output logic                                   rsp_valid,
   output logic [ptd_pkg::OUTCOME_W-1:0]          rsp_outcome,
   output logic [ptd_pkg::SLOT_W-1:0]             rsp_issued_slot,
   output logic [ptd_pkg::TOTAL_W-1:0]            rsp_dispatch_total,
   output logic [ptd_pkg::TOTAL_W-1:0]            rsp_busy_total
);

   // Sequencer state and scan pointer.  The pointer is one bit wider than a
   // slot number so that it can reach the table size itself.
   ptd_pkg::state_type                state_ff, state_in;
   logic [ptd_pkg::COUNT_W-1:0]       idx_ff, idx_in;
   logic [ptd_pkg::TICK_W-1:0]        now_ff, now_in;

   // Task tables: written by add, set-enable and report, read only at the
   // scan pointer.
   logic [ptd_pkg::TICK_W-1:0]        period_ff   [ptd_pkg::MAX_TASKS];
   logic                              enable_ff   [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TICK_W-1:0]        last_run_ff [ptd_pkg::MAX_TASKS];

   // Scheduler bookkeeping.
   logic [ptd_pkg::COUNT_W-1:0]       used_ff, used_in;
   logic                              blocking_valid_ff, blocking_valid_in;
   logic [ptd_pkg::SLOT_W-1:0]        blocking_slot_ff, blocking_slot_in;
   logic                              awaiting_ff, awaiting_in;
   logic [ptd_pkg::SLOT_W-1:0]        awaiting_slot_ff, awaiting_slot_in;
   logic                              awaiting_blk_ff, awaiting_blk_in;
   logic [ptd_pkg::TICK_W-1:0]        issued_tick_ff, issued_tick_in;
   logic [ptd_pkg::TOTAL_W-1:0]       dispatch_cnt_ff, dispatch_cnt_in;
   logic [ptd_pkg::TOTAL_W-1:0]       busy_cnt_ff, busy_cnt_in;

   // Response register.
   logic                              rsp_valid_ff, rsp_valid_in;
   ptd_pkg::outcome_type              rsp_outcome_ff, rsp_outcome_in;
   logic [ptd_pkg::SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;

   // Table write controls.
   logic                              add_we;
   logic [ptd_pkg::SLOT_W-1:0]        add_slot;
   logic                              en_we;
   logic [ptd_pkg::SLOT_W-1:0]        en_slot;
   logic                              lr_we;
   logic [ptd_pkg::SLOT_W-1:0]        lr_slot;
   logic [ptd_pkg::TICK_W-1:0]        lr_data;

   logic                              req_accept;
   logic                              start_scan;
   logic [ptd_pkg::SLOT_W-1:0]        scan_slot;
   logic                              scan_end;
   logic [ptd_pkg::TICK_W-1:0]        elapsed;
   logic                              scan_due;

   assign req_accept = start && !busy;

   // A dispatch starts a scan only when nothing is awaited and no task blocks.
   assign start_scan = req_accept && (req_func == ptd_pkg::FUNC_DISPATCH)
                       && !awaiting_ff && !blocking_valid_ff;

   // The shared unit: one wrapped subtraction and one unsigned compare on the
   // slot under the scan pointer.
   assign scan_slot = idx_ff[ptd_pkg::SLOT_W-1:0];
   assign scan_end  = (idx_ff >= used_ff);
   assign elapsed   = now_ff - last_run_ff[scan_slot];
   assign scan_due  = enable_ff[scan_slot] && (elapsed >= period_ff[scan_slot]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (start_scan) begin
               state_in = ptd_pkg::ST_SCAN;
            end
         end
         ptd_pkg::ST_SCAN: begin
            if (scan_end || scan_due) begin
               state_in = ptd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      case (state_ff)
         ptd_pkg::ST_IDLE: busy = 1'b0;
         ptd_pkg::ST_SCAN: busy = 1'b1;
         default:          busy = 1'b1;
      endcase
   end

   // Item handling and bookkeeping.
   always_comb begin
      idx_in            = idx_ff;
      now_in            = now_ff;
      used_in           = used_ff;
      blocking_valid_in = blocking_valid_ff;
      blocking_slot_in  = blocking_slot_ff;
      awaiting_in       = awaiting_ff;
      awaiting_slot_in  = awaiting_slot_ff;
      awaiting_blk_in   = awaiting_blk_ff;
      issued_tick_in    = issued_tick_ff;
      dispatch_cnt_in   = dispatch_cnt_ff;
      busy_cnt_in       = busy_cnt_ff;
      rsp_valid_in      = 1'b0;
      rsp_outcome_in    = rsp_outcome_ff;
      rsp_slot_in       = rsp_slot_ff;
      add_we            = 1'b0;
      add_slot          = used_ff[ptd_pkg::SLOT_W-1:0];
      en_we             = 1'b0;
      en_slot           = req_slot_index;
      lr_we             = 1'b0;
      lr_slot           = awaiting_slot_ff;
      lr_data           = issued_tick_ff;

      if (req_accept) begin
         rsp_valid_in   = 1'b1;
         rsp_outcome_in = ptd_pkg::OUT_OK;
         rsp_slot_in    = '0;
         case (req_func)
            ptd_pkg::FUNC_ADD: begin
               if (used_ff >= ptd_pkg::COUNT_W'(ptd_pkg::MAX_TASKS)) begin
                  rsp_outcome_in = ptd_pkg::OUT_FULL;
               end else begin
                  add_we      = 1'b1;
                  rsp_slot_in = used_ff[ptd_pkg::SLOT_W-1:0];
                  used_in     = used_ff + ptd_pkg::COUNT_W'(1);
               end
            end
            ptd_pkg::FUNC_SET_EN: begin
               if (ptd_pkg::COUNT_W'(req_slot_index) < used_ff) begin
                  en_we = 1'b1;
               end else begin
                  rsp_outcome_in = ptd_pkg::OUT_IGNORED;
               end
            end
            ptd_pkg::FUNC_DISPATCH: begin
               if (awaiting_ff) begin
                  rsp_outcome_in = ptd_pkg::OUT_IGNORED;
               end else begin
                  dispatch_cnt_in = dispatch_cnt_ff + ptd_pkg::TOTAL_W'(1);
                  if (blocking_valid_ff) begin
                     // Re-issue the task that reported busy last time.
                     busy_cnt_in      = busy_cnt_ff + ptd_pkg::TOTAL_W'(1);
                     awaiting_in      = 1'b1;
                     awaiting_slot_in = blocking_slot_ff;
                     awaiting_blk_in  = 1'b1;
                     issued_tick_in   = req_now_tick;
                     rsp_slot_in      = blocking_slot_ff;
                  end else begin
                     // The result comes at the end of the scan.
                     rsp_valid_in = 1'b0;
                     now_in       = req_now_tick;
                     idx_in       = '0;
                  end
               end
            end
            ptd_pkg::FUNC_REPORT: begin
               if (!awaiting_ff) begin
                  rsp_outcome_in = ptd_pkg::OUT_IGNORED;
               end else begin
                  if (awaiting_blk_ff) begin
                     if (req_task_status == ptd_pkg::STATUS_DONE) begin
                        lr_we             = 1'b1;
                        blocking_valid_in = 1'b0;
                     end
                  end else begin
                     if (req_task_status == ptd_pkg::STATUS_BUSY) begin
                        blocking_valid_in = 1'b1;
                        blocking_slot_in  = awaiting_slot_ff;
                     end else begin
                        lr_we = 1'b1;
                     end
                  end
                  awaiting_in = 1'b0;
                  rsp_slot_in = awaiting_slot_ff;
               end
            end
            default: begin
               rsp_outcome_in = ptd_pkg::OUT_IGNORED;
            end
         endcase
      end

      if (state_ff == ptd_pkg::ST_SCAN) begin
         if (scan_end) begin
            rsp_valid_in   = 1'b1;
            rsp_outcome_in = ptd_pkg::OUT_NONE_DUE;
            rsp_slot_in    = '0;
         end else if (scan_due) begin
            rsp_valid_in     = 1'b1;
            rsp_outcome_in   = ptd_pkg::OUT_OK;
            rsp_slot_in      = scan_slot;
            awaiting_in      = 1'b1;
            awaiting_slot_in = scan_slot;
            awaiting_blk_in  = 1'b0;
            issued_tick_in   = now_ff;
         end else begin
            idx_in = idx_ff + ptd_pkg::COUNT_W'(1);
         end
      end
   end

   // Control and bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ptd_pkg::ST_IDLE;
         used_ff           <= '0;
         blocking_valid_ff <= 1'b0;
         blocking_slot_ff  <= '0;
         awaiting_ff       <= 1'b0;
         awaiting_slot_ff  <= '0;
         awaiting_blk_ff   <= 1'b0;
         issued_tick_ff    <= '0;
         dispatch_cnt_ff   <= '0;
         busy_cnt_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         used_ff           <= used_in;
         blocking_valid_ff <= blocking_valid_in;
         blocking_slot_ff  <= blocking_slot_in;
         awaiting_ff       <= awaiting_in;
         awaiting_slot_ff  <= awaiting_slot_in;
         awaiting_blk_ff   <= awaiting_blk_in;
         issued_tick_ff    <= issued_tick_in;
         dispatch_cnt_ff   <= dispatch_cnt_in;
         busy_cnt_ff       <= busy_cnt_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      now_ff         <= now_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   // Task tables.  A new task starts with a last run of zero.
   always_ff @(posedge clock) begin
      if (add_we) begin
         period_ff[add_slot]   <= req_period_ticks;
         enable_ff[add_slot]   <= req_enable_bit;
         last_run_ff[add_slot] <= '0;
      end
      if (en_we) begin
         enable_ff[en_slot] <= req_enable_bit;
      end
      if (lr_we) begin
         last_run_ff[lr_slot] <= lr_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_issued_slot    = rsp_slot_ff;
   // The totals change only when a dispatch is taken, which cannot happen
   // before the previous result has been shown.
   assign rsp_dispatch_total = dispatch_cnt_ff;
   assign rsp_busy_total     = busy_cnt_ff;

   // A result appears only after an item was taken or while a scan finishes.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(req_accept) || ($past(state_ff) == ptd_pkg::ST_SCAN)))
      else $error("result without a taken item or a scan");

   // The fill count never passes the table size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= ptd_pkg::COUNT_W'(ptd_pkg::MAX_TASKS))
      else $error("fill count beyond table size");

   // The scan pointer never runs past the filled part of the table.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptd_pkg::ST_SCAN) |-> (idx_ff <= used_ff))
      else $error("scan pointer beyond filled slots");

   // A due slot found by the scan is issued and awaits its status.
   a_scan_issue: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ptd_pkg::ST_SCAN) && !scan_end && scan_due)
      |=> (rsp_valid && awaiting_ff && !awaiting_blk_ff
           && (rsp_issued_slot == awaiting_slot_ff)))
      else $error("due slot not issued");

   // A dispatch with a blocking task re-issues that task at once.
   a_blocking_reissue: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func == ptd_pkg::FUNC_DISPATCH) && !awaiting_ff
       && blocking_valid_ff)
      |=> (rsp_valid && (rsp_outcome == ptd_pkg::OUT_OK)
           && (rsp_issued_slot == $past(blocking_slot_ff))))
      else $error("blocking task not re-issued");

endmodule

`default_nettype wire

FILE: verif/tb_periodic_task_dispatcher.sv
`timescale 1ns / 100ps

// Testbench for the periodic task dispatcher.
//
// A driver takes items from a queue of pending requests and offers them on the
// command port, and a monitor checks every result strobe against the oldest
// expected result. The expected results come from a scheduler predictor kept
// here. It holds its own copy of the task table, the blocking task and the
// awaited status, and it is stepped once for every item the block accepts.
module tb_periodic_task_dispatcher;

   // Status values that the package leaves unnamed. Both count as "other".
   localparam logic [ptd_pkg::STATUS_W-1:0] STATUS_OTHER  = 2'd2;
   localparam logic [ptd_pkg::STATUS_W-1:0] STATUS_SPARE  = 2'd3;

   // Items queued in each idling phase; with the directed part about 1950 in all.
   localparam int PHASE_GOAL     = 640;
   // Wait after the drain, longer than the longest scan and its result, with margin.
   localparam int DRAIN_CYCLES   = 16;
   localparam int DRAIN_LIMIT    = 2000;

   typedef struct packed {
      ptd_pkg::func_type                 func;
      logic [ptd_pkg::TICK_W-1:0]        period;
      logic                              en;
      logic [ptd_pkg::SLOT_W-1:0]        slot;
      logic [ptd_pkg::TICK_W-1:0]        now;
      logic [ptd_pkg::STATUS_W-1:0]      status;
   } sched_req_type;

   typedef struct packed {
      ptd_pkg::outcome_type              outcome;
      logic [ptd_pkg::SLOT_W-1:0]        slot;
      logic [ptd_pkg::TOTAL_W-1:0]       dispatches;
      logic [ptd_pkg::TOTAL_W-1:0]       reissues;
   } sched_rsp_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [ptd_pkg::FUNC_W-1:0]        req_func = '0;
   logic [ptd_pkg::TICK_W-1:0]        req_period_ticks = '0;
   logic                              req_enable_bit = 1'b0;
   logic [ptd_pkg::SLOT_W-1:0]        req_slot_index = '0;
   logic [ptd_pkg::TICK_W-1:0]        req_now_tick = '0;
   logic [ptd_pkg::STATUS_W-1:0]      req_task_status = '0;
   logic                              rsp_valid;
   logic [ptd_pkg::OUTCOME_W-1:0]     rsp_outcome;
   logic [ptd_pkg::SLOT_W-1:0]        rsp_issued_slot;
   logic [ptd_pkg::TOTAL_W-1:0]       rsp_dispatch_total;
   logic [ptd_pkg::TOTAL_W-1:0]       rsp_busy_total;

   // Stimulus and checking bookkeeping.
   sched_req_type                     queued_requests[$];
   sched_rsp_type                     expected_results[$];
   sched_req_type                     offered_item;
   int unsigned                       idle_percent = 31;
   int unsigned                       items_queued = 0;
   int unsigned                       items_taken = 0;
   int unsigned                       error_count = 0;
   logic [ptd_pkg::TICK_W-1:0]        system_tick = '0;

   // The predictor's own view of the scheduler.
   logic [ptd_pkg::TICK_W-1:0]        task_period[ptd_pkg::MAX_TASKS];
   logic                              task_enabled[ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TICK_W-1:0]        task_last_run[ptd_pkg::MAX_TASKS];
   int unsigned                       slots_used = 0;
   logic                              blocker_valid = 1'b0;
   logic [ptd_pkg::SLOT_W-1:0]        blocker_slot = '0;
   logic                              status_pending = 1'b0;
   logic [ptd_pkg::SLOT_W-1:0]        pending_slot = '0;
   logic                              pending_from_blocker = 1'b0;
   logic [ptd_pkg::TICK_W-1:0]        pending_tick = '0;
   logic [ptd_pkg::TOTAL_W-1:0]       dispatch_count = '0;
   logic [ptd_pkg::TOTAL_W-1:0]       reissue_count = '0;

   periodic_task_dispatcher i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_period_ticks   (req_period_ticks),
      .req_enable_bit     (req_enable_bit),
      .req_slot_index     (req_slot_index),
      .req_now_tick       (req_now_tick),
      .req_task_status    (req_task_status),
      .rsp_valid          (rsp_valid),
      .rsp_outcome        (rsp_outcome),
      .rsp_issued_slot    (rsp_issued_slot),
      .rsp_dispatch_total (rsp_dispatch_total),
      .rsp_busy_total     (rsp_busy_total)
   );

   always #2 clock = ~clock;

   // Reset is held from the start of the run and released on a clock edge.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // A hard ceiling on the run, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic note_failure(string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Steps the predictor by one accepted item and returns the result that the
   // block should give for it.
   function automatic sched_rsp_type schedule_outcome(sched_req_type r);
      sched_rsp_type                  res;
      logic [ptd_pkg::TICK_W-1:0]     elapsed;
      res.outcome = ptd_pkg::OUT_OK;
      res.slot = '0;
      case (r.func)
         ptd_pkg::FUNC_ADD: begin
            if (slots_used >= ptd_pkg::MAX_TASKS) begin
               res.outcome = ptd_pkg::OUT_FULL;
            end else begin
               // A new task starts with a last run of zero.
               task_period[ptd_pkg::SLOT_W'(slots_used)] = r.period;
               task_enabled[ptd_pkg::SLOT_W'(slots_used)] = r.en;
               task_last_run[ptd_pkg::SLOT_W'(slots_used)] = '0;
               res.slot = ptd_pkg::SLOT_W'(slots_used);
               slots_used++;
            end
         end
         ptd_pkg::FUNC_SET_EN: begin
            if (r.slot < slots_used) begin
               task_enabled[r.slot] = r.en;
            end else begin
               res.outcome = ptd_pkg::OUT_IGNORED;
            end
         end
         ptd_pkg::FUNC_DISPATCH: begin
            if (status_pending) begin
               // A dispatch while a status is still owed is not counted.
               res.outcome = ptd_pkg::OUT_IGNORED;
            end else begin
               dispatch_count++;
               if (blocker_valid) begin
                  reissue_count++;
                  status_pending = 1'b1;
                  pending_slot = blocker_slot;
                  pending_from_blocker = 1'b1;
                  pending_tick = r.now;
                  res.slot = blocker_slot;
               end else begin
                  res.outcome = ptd_pkg::OUT_NONE_DUE;
                  for (int i = 0; i < slots_used; i++) begin
                     // Elapsed time wraps with the tick counter.
                     elapsed = r.now - task_last_run[ptd_pkg::SLOT_W'(i)];
                     if (task_enabled[ptd_pkg::SLOT_W'(i)]
                         && elapsed >= task_period[ptd_pkg::SLOT_W'(i)]) begin
                        status_pending = 1'b1;
                        pending_slot = ptd_pkg::SLOT_W'(i);
                        pending_from_blocker = 1'b0;
                        pending_tick = r.now;
                        res.slot = ptd_pkg::SLOT_W'(i);
                        res.outcome = ptd_pkg::OUT_OK;
                        break;
                     end
                  end
               end
            end
         end
         default: begin
            if (!status_pending) begin
               res.outcome = ptd_pkg::OUT_IGNORED;
            end else begin
               if (pending_from_blocker) begin
                  // Only done releases the blocking task.
                  if (r.status == ptd_pkg::STATUS_DONE) begin
                     task_last_run[pending_slot] = pending_tick;
                     blocker_valid = 1'b0;
                  end
               end else if (r.status == ptd_pkg::STATUS_BUSY) begin
                  blocker_valid = 1'b1;
                  blocker_slot = pending_slot;
               end else begin
                  task_last_run[pending_slot] = pending_tick;
               end
               status_pending = 1'b0;
               res.slot = pending_slot;
            end
         end
      endcase
      if (res.outcome != ptd_pkg::OUT_OK) res.slot = '0;
      res.dispatches = dispatch_count;
      res.reissues = reissue_count;
      return res;
   endfunction

   // Every field gets random content, so that the fields an operation does not
   // use still see both values on every bit.
   function automatic sched_req_type random_request(ptd_pkg::func_type f);
      sched_req_type r;
      r.func = f;
      r.period = $urandom;
      r.en = 1'($urandom);
      r.slot = ptd_pkg::SLOT_W'($urandom);
      r.now = $urandom;
      r.status = ptd_pkg::STATUS_W'($urandom);
      return r;
   endfunction

   task automatic queue_request(sched_req_type r);
      queued_requests.push_back(r);
      items_queued++;
   endtask

   task automatic queue_add(logic [ptd_pkg::TICK_W-1:0] period, logic en);
      sched_req_type r;
      r = random_request(ptd_pkg::FUNC_ADD);
      r.period = period;
      r.en = en;
      queue_request(r);
   endtask

   task automatic queue_set_enable(logic [ptd_pkg::SLOT_W-1:0] slot, logic en);
      sched_req_type r;
      r = random_request(ptd_pkg::FUNC_SET_EN);
      r.slot = slot;
      r.en = en;
      queue_request(r);
   endtask

   task automatic queue_dispatch(logic [ptd_pkg::TICK_W-1:0] now);
      sched_req_type r;
      r = random_request(ptd_pkg::FUNC_DISPATCH);
      r.now = now;
      queue_request(r);
   endtask

   task automatic queue_report(logic [ptd_pkg::STATUS_W-1:0] status);
      sched_req_type r;
      r = random_request(ptd_pkg::FUNC_REPORT);
      r.status = status;
      queue_request(r);
   endtask

   // Done is the most common answer so that blocking tasks are released again
   // before long; busy, other and the spare code share the rest.
   function automatic logic [ptd_pkg::STATUS_W-1:0] random_status();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 45) return ptd_pkg::STATUS_DONE;
      if (p < 70) return ptd_pkg::STATUS_BUSY;
      if (p < 90) return STATUS_OTHER;
      return STATUS_SPARE;
   endfunction

   // The system tick mostly creeps forward by small steps, so that the short
   // periods fall due now and then. Occasionally it jumps anywhere, or steps a
   // little backwards, which makes the wrapped elapsed time enormous.
   task automatic advance_tick();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 85) system_tick += $urandom_range(150);
      else if (p < 95) system_tick += $urandom;
      else system_tick -= $urandom_range(255);
   endtask

   // Most of the random stimulus is a dispatch followed by its report, which is
   // the sequence that drives the table through its states. The remainder is
   // enable changes, adds to the full table, and broken sequences: lone
   // dispatches, lone reports and dispatches repeated before the report.
   task automatic queue_random_sequence();
      int unsigned p;
      p = $urandom_range(99);
      advance_tick();
      if (p < 55) begin
         queue_dispatch(system_tick);
         queue_report(random_status());
      end else if (p < 70) begin
         queue_set_enable(ptd_pkg::SLOT_W'($urandom), $urandom_range(99) < 75);
      end else if (p < 80) begin
         queue_dispatch(system_tick);
      end else if (p < 87) begin
         queue_report(random_status());
      end else if (p < 93) begin
         queue_add($urandom, 1'($urandom));
      end else begin
         queue_dispatch(system_tick);
         queue_dispatch(system_tick + $urandom_range(20));
         queue_report(random_status());
      end
   endtask

   // Driver. An item stays on the port until the block takes it; when the port
   // is free the next item is offered unless the sender chooses to idle. The
   // predictor is stepped at the edge on which the block takes the item.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_results.push_back(schedule_outcome(offered_item));
            items_taken++;
         end
         if (!(start && busy)) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= idle_percent) begin
               offered_item = queued_requests.pop_front();
               start <= 1'b1;
               req_func <= offered_item.func;
               req_period_ticks <= offered_item.period;
               req_enable_bit <= offered_item.en;
               req_slot_index <= offered_item.slot;
               req_now_tick <= offered_item.now;
               req_task_status <= offered_item.status;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each result strobe is taken at the edge that ends its cycle and
   // compared field by field with the oldest expected result.
   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result with nothing expected: outcome %0d slot %0d",
                                   rsp_outcome, rsp_issued_slot));
         end else begin
            want = expected_results.pop_front();
            if (rsp_outcome !== want.outcome)
               note_failure($sformatf("outcome %0d, expected %0d",
                                      rsp_outcome, want.outcome));
            if (rsp_issued_slot !== want.slot)
               note_failure($sformatf("issued slot %0d, expected %0d",
                                      rsp_issued_slot, want.slot));
            if (rsp_dispatch_total !== want.dispatches)
               note_failure($sformatf("dispatch total %0d, expected %0d",
                                      rsp_dispatch_total, want.dispatches));
            if (rsp_busy_total !== want.reissues)
               note_failure($sformatf("busy total %0d, expected %0d",
                                      rsp_busy_total, want.reissues));
         end
      end
   end

   // Stimulus and the end of the run.
   initial begin
      int unsigned goal;
      int unsigned waited;

      while (reset) @(posedge clock);

      // Directed part. Before any task exists, a report and an enable change
      // are out of sequence, and a dispatch finds nothing due but is counted.
      queue_report(ptd_pkg::STATUS_DONE);
      queue_set_enable('0, 1'b1);
      queue_dispatch('0);

      // Fill the table: the longest possible period, a zero period that is
      // always due, a disabled task, short random periods, then one add too
      // many.
      queue_add('1, 1'b1);
      queue_add('0, 1'b1);
      queue_add(32'd100, 1'b0);
      for (int i = 3; i < ptd_pkg::MAX_TASKS; i++)
         queue_add($urandom_range(1, 400), 1'($urandom));
      queue_add('0, 1'b1);

      // The zero-period task is issued; a second dispatch before its report is
      // ignored. Busy makes it the blocking task, which is then re-issued while
      // the answers are other or the spare code, until done releases it.
      queue_dispatch(32'd5);
      queue_dispatch(32'd6);
      queue_report(ptd_pkg::STATUS_BUSY);
      queue_dispatch(32'd7);
      queue_report(STATUS_OTHER);
      queue_dispatch(32'd8);
      queue_report(STATUS_SPARE);
      queue_dispatch(32'd9);
      queue_report(ptd_pkg::STATUS_DONE);

      // At the top tick the first task has waited exactly its full period.
      queue_dispatch('1);
      queue_report(ptd_pkg::STATUS_DONE);
      queue_set_enable(3'd7, 1'b0);
      queue_set_enable(3'd1, 1'b0);
      system_tick = 32'd10;

      // Random part in three phases: the sender idles often, then more often,
      // then not at all. The results can never be held off.
      for (int phase = 0; phase < 3; phase++) begin
         idle_percent = (phase == 0) ? 31 : (phase == 1) ? 60 : 0;
         goal = items_queued + PHASE_GOAL;
         while (items_queued < goal) begin
            if (queued_requests.size() < 4) queue_random_sequence();
            else @(posedge clock);
         end
      end

      while (items_taken != items_queued) @(posedge clock);
      waited = 0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // Let a few more cycles pass so that a stray extra result is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         note_failure($sformatf("%0d expected results never arrived",
                                expected_results.size()));

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ptd_pkg.sv
rtl/periodic_task_dispatcher.sv
verif/tb_periodic_task_dispatcher.sv
